// File: rtl/bmorph_pkg.sv
// Shared constants, item type and combining functions of the 3x3 binary morphology block.
`default_nettype none

package bmorph_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int WSAT_W       = COL_W + 1;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int ROW_W        = 13;
   localparam int PIX_W        = 8;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = 2'd2;

   localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 13'd480;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [COL_W-1:0] col;
      logic             has_result;
      logic             use_left;
      logic             use_right;
      logic             use_top;
      logic             use_bot;
      logic             last;
   } item_type;

   function automatic logic [PIX_W-1:0] combine(input logic mode,
                                                input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
      return mode ? (a | b) : (a & b);
   endfunction

   function automatic logic [PIX_W-1:0] column_value(input logic mode,
                                                     input logic [PIX_W-1:0] top,
                                                     input logic [PIX_W-1:0] mid,
                                                     input logic [PIX_W-1:0] bot,
                                                     input logic use_top,
                                                     input logic use_bot);
      logic [PIX_W-1:0] v;
      v = mid;
      if (use_top) begin
         v = combine(mode, v, top);
      end
      if (use_bot) begin
         v = combine(mode, v, bot);
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// File: rtl/bmorph_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bmorph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/bmorph_ctrl.sv
// Configuration registers, raster position counters and decode of each incoming word.
`default_nettype none

module bmorph_ctrl (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [bmorph_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bmorph_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                                accept,
   input  wire logic [bmorph_pkg::PIX_W-1:0]        pixel_in,
   input  wire logic                                flush,
   output      logic                                mode,
   output      logic                                keep,
   output      bmorph_pkg::item_type                item
);

   logic                                 mode_ff;
   logic [bmorph_pkg::WIDTH_REG_W-1:0]   width_ff;
   logic [bmorph_pkg::HEIGHT_REG_W-1:0]  height_ff;
   logic [bmorph_pkg::COL_W-1:0]         col_ff;
   logic [bmorph_pkg::COL_W-1:0]         col_in;
   logic [bmorph_pkg::ROW_W-1:0]         row_ff;
   logic [bmorph_pkg::ROW_W-1:0]         row_in;

   logic [bmorph_pkg::WSAT_W-1:0]        wsat;
   logic [bmorph_pkg::COL_W-1:0]         wlast;
   logic [bmorph_pkg::ROW_W-1:0]         hsat;
   logic [bmorph_pkg::ROW_W-1:0]         hlast;
   logic [bmorph_pkg::COL_W-1:0]         col;
   logic [bmorph_pkg::ROW_W-1:0]         row;
   logic                                 drain;
   logic                                 first_col;
   logic                                 inner;
   logic                                 row_end;

   always_comb begin
      if (width_ff < 11'd2) begin
         wsat = bmorph_pkg::WSAT_W'(2);
      end else if (32'(width_ff) > 32'(bmorph_pkg::MAX_WIDTH)) begin
         wsat = bmorph_pkg::WSAT_W'(bmorph_pkg::MAX_WIDTH);
      end else begin
         wsat = bmorph_pkg::WSAT_W'(width_ff);
      end
      wlast = bmorph_pkg::COL_W'(wsat - bmorph_pkg::WSAT_W'(1));

      if (height_ff < 13'd2) begin
         hsat = bmorph_pkg::ROW_W'(2);
      end else if (32'(height_ff) > 32'(bmorph_pkg::HEIGHT_LIMIT)) begin
         hsat = bmorph_pkg::ROW_W'(bmorph_pkg::HEIGHT_LIMIT);
      end else begin
         hsat = bmorph_pkg::ROW_W'(height_ff);
      end
      hlast = hsat + bmorph_pkg::ROW_W'(1);

      col = (col_ff > wlast) ? wlast : col_ff;
      row = (row_ff > hlast) ? hlast : row_ff;

      drain     = row >= hsat;
      keep      = drain || !flush;
      first_col = col == '0;
      // A centre inside the row lags by one column; at column zero the
      // centre is the last pixel of the row before, with no right neighbor.
      inner     = !first_col && row != '0;

      item.pix        = drain ? '0 : pixel_in;
      item.col        = col;
      item.has_result = inner || (first_col && row >= bmorph_pkg::ROW_W'(2));
      item.use_left   = inner ? (col >= bmorph_pkg::COL_W'(2)) : 1'b1;
      item.use_right  = inner;
      item.use_top    = inner ? (row >= bmorph_pkg::ROW_W'(2))
                              : (row >= bmorph_pkg::ROW_W'(3));
      item.use_bot    = inner ? (row <= hsat - bmorph_pkg::ROW_W'(1)) : (row <= hsat);
      item.last       = first_col && row == hlast;

      row_end = col == wlast;
      if (!keep) begin
         col_in = col;
         row_in = row;
      end else if (first_col && row == hlast) begin
         col_in = '0;
         row_in = '0;
      end else if (row_end) begin
         col_in = '0;
         row_in = row + bmorph_pkg::ROW_W'(1);
      end else begin
         col_in = col + bmorph_pkg::COL_W'(1);
         row_in = row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         width_ff  <= bmorph_pkg::RESET_WIDTH;
         height_ff <= bmorph_pkg::RESET_HEIGHT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bmorph_pkg::CSR_MODE:   mode_ff   <= csr_wdata[0];
            bmorph_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[bmorph_pkg::WIDTH_REG_W-1:0];
            bmorph_pkg::CSR_HEIGHT: height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign mode = mode_ff;

endmodule

`default_nettype wire

// File: rtl/bmorph_window.sv
// Two-column neighborhood window and the AND/OR reduction of the 3x3 neighborhood.
`default_nettype none

module bmorph_window (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          mode,
   input  wire logic                          advance,
   input  wire bmorph_pkg::item_type          item,
   input  wire logic [bmorph_pkg::PIX_W-1:0]  top,
   input  wire logic [bmorph_pkg::PIX_W-1:0]  mid,
   output      logic [bmorph_pkg::PIX_W-1:0]  pixel_out
);

   // Entries 0..2 hold column c-2 (top, middle, bottom), 3..5 column c-1.
   logic [bmorph_pkg::PIX_W-1:0] win_ff [6];
   logic [bmorph_pkg::PIX_W-1:0] left;
   logic [bmorph_pkg::PIX_W-1:0] center;
   logic [bmorph_pkg::PIX_W-1:0] right;

   always_comb begin
      left   = item.use_left
               ? bmorph_pkg::column_value(mode, win_ff[0], win_ff[1], win_ff[2],
                                          item.use_top, item.use_bot)
               : '0;
      center = bmorph_pkg::column_value(mode, win_ff[3], win_ff[4], win_ff[5],
                                        item.use_top, item.use_bot);
      right  = item.use_right
               ? bmorph_pkg::column_value(mode, top, mid, item.pix,
                                          item.use_top, item.use_bot)
               : '0;
      pixel_out = bmorph_pkg::combine(mode, bmorph_pkg::combine(mode, left, center), right);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (advance) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= item.pix;
      end
   end

endmodule

`default_nettype wire

// File: rtl/binary_morphology_3x3.sv
// Top level of the 3x3 binary erosion/dilation block on a raster pixel stream.
//
// Usage: pixels enter on the req_ channel in raster order, one byte per word.
// After the last pixel of a frame, send image_width+1 words with req_flush set
// to drain the last row; a flush word inside the pixel phase is taken and dropped.
// Each result word on the rsp_ channel is the AND (mode 0) or OR (mode 1) of
// the pixel's 3x3 neighborhood; rsp_frame_last marks the final pixel of a frame.
// Results lag the input by one row and one pixel of the raster.
// Throughput is one word per cycle while the receiver does not stall. An accepted
// word and the two line RAM reads are registered at the accepting edge, and the
// window reduction loads the output register when the input stage advances.
// Configuration is written through csr_ while the stream is idle.
// Reset clears the configuration to erosion at 640x480, the raster position and
// the window; the line RAMs are not cleared and need no clearing pass.
// When the receiver stalls, the result stays in the output register, one more
// word waits in the input stage, and req_stall rises after that.
`default_nettype none

module binary_morphology_3x3 (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [bmorph_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bmorph_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [bmorph_pkg::PIX_W-1:0]        req_pixel_in,
   input  wire logic                                req_flush,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [bmorph_pkg::PIX_W-1:0]        rsp_pixel_out,
   output      logic                                rsp_frame_last
);

   logic                          accept;
   logic                          keep;
   logic                          load;
   logic                          mode;
   logic                          advance;
   bmorph_pkg::item_type          item;
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   bmorph_pkg::item_type          s1_item_ff;
   logic [bmorph_pkg::PIX_W-1:0]  upper_rd;
   logic [bmorph_pkg::PIX_W-1:0]  middle_rd;
   logic [bmorph_pkg::PIX_W-1:0]  window_pixel;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [bmorph_pkg::PIX_W-1:0]  rsp_pixel_ff;
   logic                          rsp_last_ff;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign load      = accept && keep;

   bmorph_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .accept           (accept),
      .pixel_in         (req_pixel_in),
      .flush            (req_flush),
      .mode             (mode),
      .keep             (keep),
      .item             (item)
   );

   bmorph_ram #(
      .WIDTH (bmorph_pkg::PIX_W),
      .DEPTH (bmorph_pkg::MAX_WIDTH)
   ) u_upper_line (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (s1_item_ff.col),
      .wr_data (middle_rd),
      .rd_en   (load),
      .rd_addr (item.col),
      .rd_data (upper_rd)
   );

   bmorph_ram #(
      .WIDTH (bmorph_pkg::PIX_W),
      .DEPTH (bmorph_pkg::MAX_WIDTH)
   ) u_middle_line (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (s1_item_ff.col),
      .wr_data (s1_item_ff.pix),
      .rd_en   (load),
      .rd_addr (item.col),
      .rd_data (middle_rd)
   );

   bmorph_window u_window (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode),
      .advance   (advance),
      .item      (s1_item_ff),
      .top       (upper_rd),
      .mid       (middle_rd),
      .pixel_out (window_pixel)
   );

   always_comb begin
      if (load) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (advance && s1_item_ff.has_result) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_item_ff <= item;
      end
      if (advance && s1_item_ff.has_result) begin
         rsp_pixel_ff <= window_pixel;
         rsp_last_ff  <= s1_item_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/bmorph_checker.sv
// Port-level assertions for the 3x3 binary morphology block and their bind.
`default_nettype none

module bmorph_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall
);

   // A result word waits while the receiver stalls.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   // With the output register free, the input stage can always move on.
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with an empty output register");

   // Without new words and with a free receiver, the pipeline drains.
   a_drains: assert property (@(posedge clock) disable iff (reset)
      !req_valid ##1 (!req_valid && !rsp_stall) ##1 (!req_valid && !rsp_stall)
      |=> !rsp_valid)
      else $error("result word appeared without an input word");

endmodule

bind binary_morphology_3x3 bmorph_checker u_bmorph_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);

`default_nettype wire
